// ===== src/length_prefixed_packet_ring_unit_macros.svh =====
// Assertion macros used by the checker file.
`ifndef LENGTH_PREFIXED_PACKET_RING_UNIT_MACROS_SVH
`define LENGTH_PREFIXED_PACKET_RING_UNIT_MACROS_SVH
// Same-cycle implication, disabled during reset.
`define LPR_ASSERT_NOW(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication, disabled during reset.
`define LPR_ASSERT_NEXT(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) else $error(msg);
`endif

// ===== src/lpr_pkg.sv =====
// ----------------------------------------------------------------------------
// lpr_pkg
// Shared types, status codes and index helpers of the packet ring.
// ----------------------------------------------------------------------------
package lpr_pkg;

  localparam int RING_DEPTH = 1024;
  localparam int IDX_W = $clog2(RING_DEPTH);
  localparam int CNT_W = IDX_W + 1;

  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_NO_DATA    = 3'd1;
  localparam logic [2:0] ST_OVERFLOW   = 3'd2;
  localparam logic [2:0] ST_TOO_BIG    = 3'd3;
  localparam logic [2:0] ST_CORRUPTED  = 3'd4;
  localparam logic [2:0] ST_BAD_ARGS   = 3'd5;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_READ  = 2'd1,
    OP_SKIP  = 2'd2,
    OP_CLEAR = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_HDR
  } state_t;

  // One queued request beat.
  typedef struct packed {
    op_t         op;
    logic [31:0] data_word;
    logic        last_word;
    logic [10:0] limit_words;
  } item_t;

  // Ring index plus offset, modulo the active capacity. The sum stays below
  // twice the capacity, so one conditional subtract suffices.
  function automatic logic [IDX_W-1:0] wrap_idx(input logic [IDX_W-1:0] a,
                                                input logic [CNT_W-1:0] b,
                                                input logic [CNT_W-1:0] cap);
    logic [CNT_W:0] sum;
    sum = {2'b00, a} + {1'b0, b};
    if (sum >= {1'b0, cap}) begin
      sum = sum - {1'b0, cap};
    end
    return sum[IDX_W-1:0];
  endfunction

endpackage

// ===== src/lpr_front.sv =====
// ----------------------------------------------------------------------------
// lpr_front
// Accepts request beats, decodes the request type and queues them.
// ----------------------------------------------------------------------------
module lpr_front import lpr_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  req_type,
  input  logic [31:0] data_word,
  input  logic        last_word,
  input  logic [10:0] limit_words,
  output logic        q_valid,
  output item_t       q_item,
  input  logic        q_pop
);

  item_t      slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  logic       pop;
  item_t      new_item;

  // Classify the incoming beat.
  always_comb begin
    new_item.op          = op_t'(req_type);
    new_item.data_word   = data_word;
    new_item.last_word   = last_word;
    new_item.limit_words = limit_words;
  end

  assign in_ready = (count != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (count != 2'd0);
  assign pop      = q_pop && q_valid;
  assign q_item   = slots[rd_ptr];

  // Two-entry queue pointers.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  // Queue storage.
  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= new_item;
  end

endmodule

// ===== src/lpr_back.sv =====
// ----------------------------------------------------------------------------
// lpr_back
// Executes queued requests against the word ring and drives the result.
// ----------------------------------------------------------------------------
module lpr_back import lpr_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [10:0]      cfg_data,
  input  logic             q_valid,
  input  item_t            q_item,
  output logic             q_pop,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [2:0]       status,
  output logic             data_valid,
  output logic [31:0]      read_data,
  output logic             read_last,
  output logic [9:0]       packet_words,
  output logic [10:0]      fill_words
);

  logic [31:0]      ring_memory [RING_DEPTH];
  logic [31:0]      rd_q;

  state_t           state, state_next;
  item_t            cur;
  logic [CNT_W-1:0] cap;
  logic [CNT_W-1:0] fill_count, fill_next;
  logic [IDX_W-1:0] head_index, head_next;
  logic [IDX_W-1:0] tail_index, tail_next;
  logic [CNT_W-1:0] write_pending, pending_next;
  logic             write_rejected, rejected_next;
  logic [IDX_W-1:0] read_remaining, remaining_next;
  logic             read_active, active_next;
  logic [IDX_W-1:0] read_length, length_next;
  logic [IDX_W-1:0] hdr_addr, hdr_addr_next;
  logic [CNT_W-1:0] hdr_val, hdr_val_next;

  logic             exec_go;
  logic             mem_we;
  logic [IDX_W-1:0] mem_addr;
  logic             commit;

  logic [2:0]       r_status;
  logic             r_valid, r_last;
  logic [31:0]      r_data;
  logic [9:0]       r_pwords;

  logic [CNT_W-1:0] n_words;
  logic [CNT_W+1:0] need;
  logic [IDX_W-1:0] rem_dec;
  logic [CNT_W-1:0] hdr_len;
  logic             hdr_big;

  assign exec_go = (state == S_EXEC) && (!out_valid || out_ready);
  assign n_words = write_pending + 1'b1;
  assign need    = {2'b00, fill_count} + {2'b00, n_words} + 1'b1;
  assign rem_dec = (read_remaining != '0) ? read_remaining - 1'b1 : read_remaining;
  assign hdr_big = |rd_q[31:CNT_W];
  assign hdr_len = rd_q[CNT_W-1:0];

  // Next-state logic.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (q_valid) state_next = S_EXEC;
      S_EXEC: begin
        if (exec_go) state_next = commit ? S_HDR : S_IDLE;
      end
      S_HDR:  state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // Request execution: ring state updates, memory writes and result.
  always_comb begin
    fill_next      = fill_count;
    head_next      = head_index;
    tail_next      = tail_index;
    pending_next   = write_pending;
    rejected_next  = write_rejected;
    remaining_next = read_remaining;
    active_next    = read_active;
    length_next    = read_length;
    hdr_addr_next  = hdr_addr;
    hdr_val_next   = hdr_val;
    mem_we         = 1'b0;
    mem_addr       = hdr_addr;
    commit         = 1'b0;
    r_status       = ST_OK;
    r_valid        = 1'b0;
    r_data         = '0;
    r_last         = 1'b0;
    r_pwords       = '0;
    q_pop          = (state == S_IDLE) && q_valid;
    case (cur.op)
      OP_WRITE: begin
        if (write_rejected || (need > {2'b00, cap})) begin
          rejected_next = 1'b1;
          r_status = (fill_count == '0) ? ST_TOO_BIG : ST_OVERFLOW;
          if (cur.last_word) begin
            pending_next  = '0;
            rejected_next = 1'b0;
          end
        end else begin
          mem_we       = (state == S_EXEC);
          mem_addr     = wrap_idx(tail_index, n_words, cap);
          pending_next = n_words;
          if (cur.last_word) begin
            commit        = 1'b1;
            hdr_addr_next = tail_index;
            hdr_val_next  = n_words;
            tail_next     = wrap_idx(tail_index, n_words + 1'b1, cap);
            fill_next     = need[CNT_W-1:0];
            pending_next  = '0;
          end
        end
      end
      OP_READ: begin
        if (read_active) begin
          r_data         = rd_q;
          r_valid        = 1'b1;
          head_next      = wrap_idx(head_index, CNT_W'(1), cap);
          if (fill_count != '0) fill_next = fill_count - 1'b1;
          remaining_next = rem_dec;
          r_pwords       = read_length;
          if (rem_dec == '0) begin
            r_last      = 1'b1;
            active_next = 1'b0;
          end
        end else if (cur.limit_words == '0) begin
          r_status = ST_BAD_ARGS;
        end else if (fill_count == '0) begin
          r_status = ST_NO_DATA;
        end else begin
          r_pwords = (|rd_q[31:10]) ? 10'h3FF : rd_q[9:0];
          if (hdr_big || (hdr_len > cur.limit_words)) begin
            r_status = ST_OVERFLOW;
          end else if (hdr_len >= fill_count) begin
            r_status = ST_CORRUPTED;
          end else begin
            head_next      = wrap_idx(head_index, CNT_W'(1), cap);
            fill_next      = fill_count - 1'b1;
            length_next    = hdr_len[IDX_W-1:0];
            remaining_next = hdr_len[IDX_W-1:0];
            active_next    = (hdr_len != '0);
          end
        end
      end
      OP_SKIP: begin
        if (read_active) begin
          head_next = wrap_idx(head_index, {1'b0, read_remaining}, cap);
          fill_next = (fill_count > {1'b0, read_remaining}) ?
                      fill_count - {1'b0, read_remaining} : '0;
          r_pwords       = read_length;
          remaining_next = '0;
          active_next    = 1'b0;
        end else if (fill_count == '0) begin
          r_status = ST_NO_DATA;
        end else if (hdr_big || (hdr_len >= fill_count)) begin
          r_status = ST_CORRUPTED;
        end else begin
          head_next = wrap_idx(head_index, hdr_len + 1'b1, cap);
          fill_next = fill_count - hdr_len - 1'b1;
          r_pwords  = hdr_len[9:0];
        end
      end
      default: begin
        fill_next      = '0;
        head_next      = '0;
        tail_next      = '0;
        pending_next   = '0;
        rejected_next  = 1'b0;
        remaining_next = '0;
        active_next    = 1'b0;
        length_next    = '0;
      end
    endcase
    // The cycle after a commit stores the length word at the reserved slot.
    if (state == S_HDR) begin
      mem_we   = 1'b1;
      mem_addr = hdr_addr;
    end
  end

  // State and ring control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      cap            <= CNT_W'(RING_DEPTH);
      fill_count     <= '0;
      head_index     <= '0;
      tail_index     <= '0;
      write_pending  <= '0;
      write_rejected <= 1'b0;
      read_remaining <= '0;
      read_active    <= 1'b0;
      read_length    <= '0;
      out_valid      <= 1'b0;
    end else begin
      state <= state_next;
      if (out_valid && out_ready) out_valid <= 1'b0;
      if (cfg_we) begin
        if (cfg_data < 11'd2) begin
          cap <= CNT_W'(2);
        end else if (cfg_data > 11'(RING_DEPTH)) begin
          cap <= CNT_W'(RING_DEPTH);
        end else begin
          cap <= cfg_data[CNT_W-1:0];
        end
        fill_count     <= '0;
        head_index     <= '0;
        tail_index     <= '0;
        write_pending  <= '0;
        write_rejected <= 1'b0;
        read_remaining <= '0;
        read_active    <= 1'b0;
        read_length    <= '0;
      end else if (exec_go) begin
        fill_count     <= fill_next;
        head_index     <= head_next;
        tail_index     <= tail_next;
        write_pending  <= pending_next;
        write_rejected <= rejected_next;
        read_remaining <= remaining_next;
        read_active    <= active_next;
        read_length    <= length_next;
        out_valid      <= 1'b1;
      end
    end
  end

  // Payload registers: current request, header slot and result.
  always_ff @(posedge clk) begin
    if (q_pop) cur <= q_item;
    if (exec_go) begin
      hdr_addr     <= hdr_addr_next;
      hdr_val      <= hdr_val_next;
      status       <= r_status;
      data_valid   <= r_valid;
      read_data    <= r_data;
      read_last    <= r_last;
      packet_words <= r_pwords;
      fill_words   <= fill_next;
    end
  end

  // Ring memory: one write port, registered read at the head.
  always_ff @(posedge clk) begin
    if (mem_we && (exec_go || state == S_HDR)) begin
      ring_memory[mem_addr] <= (state == S_HDR) ? {{(32-CNT_W){1'b0}}, hdr_val}
                                                : cur.data_word;
    end
    rd_q <= ring_memory[head_index];
  end

endmodule

// ===== src/length_prefixed_packet_ring_unit.sv =====
// Flow: a request is popped from the queue in S_IDLE and executed in S_EXEC,
// where its result is registered; a write beat that commits a packet then
// passes through S_HDR to store the length word. A new request is taken only
// after the last one is through, and a stalled result holds the executor.
// Reset: synchronous, clears the ring to empty and capacity to 1024 words.
// ----------------------------------------------------------------------------
// length_prefixed_packet_ring_unit
// Top level of the length-prefixed packet ring: request queue and executor.
// ----------------------------------------------------------------------------
module length_prefixed_packet_ring_unit import lpr_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [10:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  req_type,
  input  logic [31:0] data_word,
  input  logic        last_word,
  input  logic [10:0] limit_words,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  status,
  output logic        data_valid,
  output logic [31:0] read_data,
  output logic        read_last,
  output logic [9:0]  packet_words,
  output logic [10:0] fill_words
);

  logic  q_valid;
  logic  q_pop;
  item_t q_item;

  // Configuration beats are always taken.
  assign cfg_ready = 1'b1;

  lpr_front u_front (
    .clk, .rst, .in_valid, .in_ready, .req_type, .data_word, .last_word,
    .limit_words, .q_valid, .q_item, .q_pop
  );

  lpr_back u_back (
    .clk, .rst,
    .cfg_we (cfg_valid && cfg_ready),
    .cfg_data,
    .q_valid, .q_item, .q_pop,
    .out_valid, .out_ready, .status, .data_valid, .read_data, .read_last,
    .packet_words, .fill_words
  );

endmodule

// ===== src/lpr_checker.sv =====
// ----------------------------------------------------------------------------
// lpr_checker
// Port-level checks on the result channel of the packet ring.
// ----------------------------------------------------------------------------
`include "length_prefixed_packet_ring_unit_macros.svh"
module lpr_checker import lpr_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  status,
  input logic        data_valid,
  input logic [31:0] read_data,
  input logic        read_last,
  input logic [10:0] fill_words
);

  // A stalled result beat holds.
  `LPR_ASSERT_NEXT(a_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(status) && $stable(read_data), "result beat changed while stalled")
  // No data word means zero data and no last flag.
  `LPR_ASSERT_NOW(a_nodata, clk, rst, out_valid && !data_valid, read_data == 32'd0 && read_last == 1'b0, "stray read data")
  // A data word is only delivered with ok status.
  `LPR_ASSERT_NOW(a_data_ok, clk, rst, out_valid && data_valid, status == ST_OK, "data beat with error status")
  // Fill never passes the ring depth.
  `LPR_ASSERT_NOW(a_fill, clk, rst, out_valid, fill_words <= 11'd1024, "fill above ring depth")

endmodule

bind length_prefixed_packet_ring_unit lpr_checker u_lpr_checker (
  .clk, .rst, .out_valid, .out_ready, .status, .data_valid, .read_data,
  .read_last, .fill_words
);

// ===== verif/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the length-prefixed packet ring. A clocked driver
// sends request beats from a queue and predicts each result at the moment the
// beat is accepted. A clocked monitor compares every result beat with the
// oldest prediction. Several ring capacities are exercised, with random gaps
// and stalls on both sides.
// ----------------------------------------------------------------------------
module tb_top import lpr_pkg::*; ();

  // Request beat as queued for the driver.
  typedef struct {
    op_t         op;
    logic [31:0] word;
    logic        last;
    logic [10:0] limit;
  } req_t;

  // Result beat as the ring should produce it.
  typedef struct {
    logic [2:0]  status;
    logic        data_valid;
    logic [31:0] read_data;
    logic        read_last;
    logic [9:0]  packet_words;
    logic [10:0] fill_words;
  } result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [10:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  req_type = '0;
  logic [31:0] data_word = '0;
  logic        last_word = 1'b0;
  logic [10:0] limit_words = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  status;
  logic        data_valid;
  logic [31:0] read_data;
  logic        read_last;
  logic [9:0]  packet_words;
  logic [10:0] fill_words;

  length_prefixed_packet_ring_unit DUT (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .req_type(req_type),
    .data_word(data_word), .last_word(last_word), .limit_words(limit_words),
    .out_valid(out_valid), .out_ready(out_ready), .status(status),
    .data_valid(data_valid), .read_data(read_data), .read_last(read_last),
    .packet_words(packet_words), .fill_words(fill_words)
  );

  req_t    pending_reqs[$];
  result_t expected_results[$];
  int      error_count = 0;
  bit      sender_hold = 1'b0;
  int      long_stall_requests = 0;

  // Shadow copy of the ring state.
  logic [31:0] shadow_mem [RING_DEPTH];
  int unsigned cap_setting;
  int unsigned fill, head, tail, wr_pending, rd_remaining, rd_length;
  bit          wr_rejected, rd_active;

  initial begin
    forever #6 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("TEST FAILED");
    $finish;
  end

  function automatic int unsigned ring_size();
    if (cap_setting < 2) return 2;
    if (cap_setting > RING_DEPTH) return RING_DEPTH;
    return cap_setting;
  endfunction

  function automatic int unsigned ring_add(int unsigned a, int unsigned b);
    return (a + b) % ring_size();
  endfunction

  function automatic void empty_shadow();
    fill = 0; head = 0; tail = 0; wr_pending = 0; wr_rejected = 0;
    rd_remaining = 0; rd_active = 0; rd_length = 0;
  endfunction

  // Advance the shadow ring by one request and return the result it gives.
  function automatic result_t predict_ring_step(req_t r);
    result_t     res;
    int unsigned n, h;
    res = '{ST_OK, 1'b0, 32'd0, 1'b0, 10'd0, 11'd0};
    case (r.op)
      OP_WRITE: begin
        n = wr_pending + 1;
        if (wr_rejected || fill + n + 1 > ring_size()) begin
          wr_rejected = 1;
          res.status = (fill == 0) ? ST_TOO_BIG : ST_OVERFLOW;
          if (r.last) begin
            wr_pending = 0;
            wr_rejected = 0;
          end
        end else begin
          shadow_mem[ring_add(tail, n)] = r.word;
          wr_pending = n;
          if (r.last) begin
            shadow_mem[tail] = n;
            tail = ring_add(tail, n + 1);
            fill += n + 1;
            wr_pending = 0;
          end
        end
      end
      OP_READ: begin
        if (rd_active) begin
          res.read_data = shadow_mem[head];
          res.data_valid = 1'b1;
          head = ring_add(head, 1);
          if (fill > 0) fill--;
          if (rd_remaining > 0) rd_remaining--;
          res.packet_words = 10'(rd_length);
          if (rd_remaining == 0) begin
            res.read_last = 1'b1;
            rd_active = 0;
          end
        end else if (r.limit == 0) begin
          res.status = ST_BAD_ARGS;
        end else if (fill == 0) begin
          res.status = ST_NO_DATA;
        end else begin
          h = shadow_mem[head];
          res.packet_words = (h > 1023) ? 10'd1023 : h[9:0];
          if (h > r.limit) begin
            res.status = ST_OVERFLOW;
          end else if (h + 1 > fill) begin
            res.status = ST_CORRUPTED;
          end else begin
            head = ring_add(head, 1);
            fill--;
            rd_length = h;
            rd_remaining = h;
            rd_active = (h != 0);
          end
        end
      end
      OP_SKIP: begin
        if (rd_active) begin
          head = ring_add(head, rd_remaining);
          fill = (fill > rd_remaining) ? fill - rd_remaining : 0;
          res.packet_words = 10'(rd_length);
          rd_remaining = 0;
          rd_active = 0;
        end else if (fill == 0) begin
          res.status = ST_NO_DATA;
        end else begin
          h = shadow_mem[head];
          if (h + 1 > fill) begin
            res.status = ST_CORRUPTED;
          end else begin
            head = ring_add(head, h + 1);
            fill -= h + 1;
            res.packet_words = 10'(h);
          end
        end
      end
      default: empty_shadow();
    endcase
    res.fill_words = 11'(fill);
    return res;
  endfunction

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(99);
    if (roll < 60) return 0;
    if (roll < 92) return $urandom_range(3, 1);
    return $urandom_range(30, 5);
  endfunction

  // Driver: predicts on each accepted beat, then offers the next one.
  int send_gap = 0;
  always @(posedge clk) begin
    req_t cur, nxt;
    bit   nv;
    if (!rst) begin
      nv = in_valid;
      if (in_valid && in_ready) begin
        cur = '{op_t'(req_type), data_word, last_word, limit_words};
        expected_results.push_back(predict_ring_step(cur));
        nv = 1'b0;
      end
      if (!nv) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (!sender_hold && pending_reqs.size() > 0) begin
          nxt = pending_reqs.pop_front();
          req_type <= nxt.op;
          data_word <= nxt.word;
          last_word <= nxt.last;
          limit_words <= nxt.limit;
          nv = 1'b1;
          send_gap = pick_gap();
        end
      end
      in_valid <= nv;
    end
  end

  // Monitor: random back-pressure and field-by-field comparison.
  int stall_left = 0;
  int long_stalls_done = 0;
  always @(posedge clk) begin
    result_t want;
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $error("result beat with no prediction waiting");
          error_count++;
        end else begin
          want = expected_results.pop_front();
          if (status !== want.status) begin
            $error("status exp %0d got %0d", want.status, status); error_count++;
          end
          if (data_valid !== want.data_valid) begin
            $error("data_valid exp %0d got %0d", want.data_valid, data_valid);
            error_count++;
          end
          if (read_data !== want.read_data) begin
            $error("read_data exp %h got %h", want.read_data, read_data);
            error_count++;
          end
          if (read_last !== want.read_last) begin
            $error("read_last exp %0d got %0d", want.read_last, read_last);
            error_count++;
          end
          if (packet_words !== want.packet_words) begin
            $error("packet_words exp %0d got %0d", want.packet_words, packet_words);
            error_count++;
          end
          if (fill_words !== want.fill_words) begin
            $error("fill_words exp %0d got %0d", want.fill_words, fill_words);
            error_count++;
          end
        end
      end
      if (long_stalls_done != long_stall_requests) begin
        long_stalls_done++;
        stall_left = 300;
        out_ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        stall_left = pick_gap();
        out_ready <= (stall_left == 0) || ($urandom_range(3) == 0);
      end
    end
  end

  task automatic push_req(op_t op, logic [31:0] w, logic l, logic [10:0] lim);
    pending_reqs.push_back('{op, w, l, lim});
  endtask

  task automatic push_packet(int len);
    for (int i = 0; i < len; i++) begin
      push_req(OP_WRITE, $urandom, i == len - 1, 11'd0);
    end
  endtask

  function automatic logic [10:0] pick_limit();
    int roll;
    roll = $urandom_range(99);
    if (roll < 8) return 11'd0;
    if (roll < 30) return 11'($urandom_range(8, 1));
    if (roll < 45) return 11'($urandom_range(1024, 9));
    return 11'd1024;
  endfunction

  // Mostly whole packets written and read back, plus skips, clears and noise.
  task automatic push_random(int count, int max_len);
    int roll, len;
    while (count > 0) begin
      roll = $urandom_range(99);
      if (roll < 40) begin
        len = ($urandom_range(19) == 0) ? $urandom_range(max_len, 1)
                                        : $urandom_range(max_len < 8 ? max_len : 8, 1);
        push_packet(len);
        count -= len;
      end else if (roll < 78) begin
        len = $urandom_range(10, 1);
        for (int i = 0; i < len; i++) begin
          push_req(OP_READ, $urandom, 1'($urandom), pick_limit());
        end
        count -= len;
      end else if (roll < 88) begin
        push_req(OP_SKIP, $urandom, 1'($urandom), 11'($urandom));
        count--;
      end else if (roll < 91) begin
        push_req(OP_CLEAR, $urandom, 1'($urandom), 11'($urandom));
        count--;
      end else begin
        push_req(op_t'($urandom_range(2)), $urandom, 1'($urandom), pick_limit());
        count--;
      end
    end
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (pending_reqs.size() != 0 || in_valid || expected_results.size() != 0);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_capacity(logic [10:0] cap);
    cfg_data <= cap;
    cfg_valid <= 1'b1;
    do @(posedge clk);
    while (!cfg_ready);
    cfg_valid <= 1'b0;
    cap_setting = cap;
    empty_shadow();
  endtask

  initial begin
    int cap_list [6] = '{2, 3, 17, 64, 1023, 1024};
    cap_setting = 1024;
    empty_shadow();
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed opening at full capacity.
    push_req(OP_READ, 32'd0, 1'b0, 11'd1024);
    push_req(OP_READ, 32'd0, 1'b0, 11'd0);
    push_req(OP_SKIP, 32'd0, 1'b0, 11'd0);
    push_req(OP_WRITE, 32'hFFFF_FFFF, 1'b1, 11'd0);
    push_req(OP_WRITE, 32'd0, 1'b0, 11'd0);
    push_req(OP_WRITE, 32'h5555_5555, 1'b0, 11'd0);
    push_req(OP_WRITE, 32'hAAAA_AAAA, 1'b1, 11'd0);
    push_req(OP_READ, 32'd0, 1'b0, 11'd1024);
    push_req(OP_READ, 32'd0, 1'b0, 11'd1024);
    push_req(OP_READ, 32'd0, 1'b0, 11'd1);
    push_req(OP_READ, 32'd0, 1'b0, 11'd1024);
    push_req(OP_READ, 32'd0, 1'b0, 11'd0);
    push_req(OP_SKIP, 32'd0, 1'b0, 11'd0);
    push_req(OP_READ, 32'd0, 1'b0, 11'd2047);
    push_req(OP_WRITE, 32'h1234_5678, 1'b1, 11'd0);
    push_req(OP_CLEAR, 32'd0, 1'b0, 11'd0);
    push_req(OP_READ, 32'd0, 1'b0, 11'd1024);
    wait_drained();

    // Small capacities first, with a long receiver stall while the sender
    // keeps offering, and a mid-phase sender pause until all results are in.
    foreach (cap_list[k]) begin
      write_capacity(11'(cap_list[k]));
      if (k == 2) long_stall_requests++;
      push_random(35, cap_list[k] > 40 ? 40 : cap_list[k] + 1);
      if (k == 3) begin
        sender_hold = 1'b1;
        wait (pending_reqs.size() == 0 || expected_results.size() == 0);
        do @(posedge clk); while (in_valid || expected_results.size() != 0);
        sender_hold = 1'b0;
      end
      push_random(35, cap_list[k] > 40 ? 40 : cap_list[k] + 1);
      wait_drained();
    end

    // Large packets that fill most of a 200-word ring, one that fills it
    // exactly, then the out-of-range capacity settings that clamp.
    write_capacity(11'd200);
    push_packet(190);
    push_packet(30);
    push_req(OP_READ, 32'd0, 1'b0, 11'd1024);
    push_req(OP_SKIP, 32'd0, 1'b0, 11'd0);
    push_req(OP_SKIP, 32'd0, 1'b0, 11'd0);
    push_packet(199);
    push_req(OP_READ, 32'd0, 1'b0, 11'd199);
    push_req(OP_READ, 32'd0, 1'b0, 11'd1024);
    push_req(OP_SKIP, 32'd0, 1'b0, 11'd0);
    wait_drained();
    write_capacity(11'd0);
    push_random(40, 3);
    wait_drained();
    write_capacity(11'd2047);
    push_random(60, 30);
    wait_drained();

    if (error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
